### sv/blr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; imported by every module of the block.
package blr_pkg;

   // command codes carried in req_tuser
   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_START   = 1'b1;

   // configuration port layout
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam int ORIGIN_BITS    = 11;
   localparam int WINDOW_BITS    = 12;
   localparam int SCREEN_BITS    = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_X      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Y      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_HEIGHT = 2'd3;

   localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RESET      = 11'd400;
   localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RESET      = 11'd300;
   localparam logic [WINDOW_BITS-1:0] WINDOW_WIDTH_RESET  = 12'd800;
   localparam logic [WINDOW_BITS-1:0] WINDOW_HEIGHT_RESET = 12'd600;

   // walk direction of the current line
   typedef struct packed {
      logic steep;       // y is the major axis
      logic x_backward;
      logic y_backward;
   } dir_type;

   // screen mapping registers
   typedef struct packed {
      logic [ORIGIN_BITS-1:0] origin_x;
      logic [ORIGIN_BITS-1:0] origin_y;
      logic [WINDOW_BITS-1:0] window_width;
      logic [WINDOW_BITS-1:0] window_height;
   } view_type;

endpackage

### sv/bresenham_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// Bresenham line rasterizer, top level. Uses blr_pkg, blr_line_step, blr_pixel_map.
// A pixel is registered and appears on rsp in the cycle after its command item is accepted.
// Throughput: one item per cycle; the line state and the single result register
// update in the accept cycle, so req_tready only drops while a result is stalled.
// Reset (synchronous): line walk idle, result register empty, view registers at defaults.
module bresenham_line_rasterizer_unit #(
   parameter int COORD_BITS = 11,
   parameter int COLOR_BITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: start_x, start_y, end_x, end_y, color (from bit 0 up), zero padded
   input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: command
   input  logic                                  req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: screen_x, screen_y, pixel_color (from bit 0 up), zero padded
   output logic [((2*blr_pkg::SCREEN_BITS+COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: in_window
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [blr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [blr_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import blr_pkg::*;

   localparam int N     = COORD_BITS;
   localparam int E     = COORD_BITS + 3;
   localparam int RSP_W = ((2*SCREEN_BITS+COLOR_BITS+7)/8)*8;

   // input fields
   logic signed [N-1:0]          start_x, start_y, end_x, end_y;
   logic        [COLOR_BITS-1:0] color;

   assign start_x = req_tdata[N-1:0];
   assign start_y = req_tdata[2*N-1:N];
   assign end_x   = req_tdata[3*N-1:2*N];
   assign end_y   = req_tdata[4*N-1:3*N];
   assign color   = req_tdata[4*N+COLOR_BITS-1:4*N];

   // line state
   logic signed [N-1:0]          cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic        [N-1:0]          remaining_ff, remaining_in;
   logic signed [E-1:0]          error_ff, error_in;
   logic        [N-1:0]          abs_dx_ff, abs_dy_ff, abs_dx_in, abs_dy_in;
   dir_type                      dir_ff, dir_in;
   logic                         busy_ff;
   logic        [COLOR_BITS-1:0] line_color_ff, line_color_in;
   view_type                     view_ff;

   // result register
   logic [RSP_W-1:0]             rsp_data_ff;
   logic                         rsp_user_ff, rsp_last_ff, rsp_valid_ff;

   logic                         accept, is_start, step_go;
   logic signed [SCREEN_BITS-1:0] screen_x, screen_y;
   logic                         in_window;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = req_tuser == CMD_START;
   // an advance with no line in progress is consumed without a result
   assign step_go    = accept && (is_start || busy_ff);

   assign line_color_in = is_start ? color : line_color_ff;

   blr_line_step #(.COORD_BITS(COORD_BITS)) u_step (
      .start          (is_start),
      .start_x        (start_x),
      .start_y        (start_y),
      .end_x          (end_x),
      .end_y          (end_y),
      .cur_x          (cur_x_ff),
      .cur_y          (cur_y_ff),
      .remaining      (remaining_ff),
      .error_term     (error_ff),
      .abs_dx         (abs_dx_ff),
      .abs_dy         (abs_dy_ff),
      .dir            (dir_ff),
      .next_cur_x     (cur_x_in),
      .next_cur_y     (cur_y_in),
      .next_remaining (remaining_in),
      .next_error     (error_in),
      .next_abs_dx    (abs_dx_in),
      .next_abs_dy    (abs_dy_in),
      .next_dir       (dir_in)
   );

   blr_pixel_map #(.COORD_BITS(COORD_BITS)) u_map (
      .cur_x     (cur_x_in),
      .cur_y     (cur_y_in),
      .view      (view_ff),
      .screen_x  (screen_x),
      .screen_y  (screen_y),
      .in_window (in_window)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         remaining_ff  <= '0;
         error_ff      <= '0;
         abs_dx_ff     <= '0;
         abs_dy_ff     <= '0;
         dir_ff        <= '0;
         busy_ff       <= 1'b0;
         line_color_ff <= '0;
      end else if (step_go) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         remaining_ff  <= remaining_in;
         error_ff      <= error_in;
         abs_dx_ff     <= abs_dx_in;
         abs_dy_ff     <= abs_dy_in;
         dir_ff        <= dir_in;
         busy_ff       <= remaining_in != '0;
         line_color_ff <= line_color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_data_ff <= RSP_W'({line_color_in, screen_y, screen_x});
         rsp_user_ff <= in_window;
         rsp_last_ff <= remaining_in == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.origin_x      <= ORIGIN_X_RESET;
         view_ff.origin_y      <= ORIGIN_Y_RESET;
         view_ff.window_width  <= WINDOW_WIDTH_RESET;
         view_ff.window_height <= WINDOW_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      view_ff.origin_x      <= csr_wdata[ORIGIN_BITS-1:0];
            CSR_ORIGIN_Y:      view_ff.origin_y      <= csr_wdata[ORIGIN_BITS-1:0];
            CSR_WINDOW_WIDTH:  view_ff.window_width  <= csr_wdata[WINDOW_BITS-1:0];
            CSR_WINDOW_HEIGHT: view_ff.window_height <= csr_wdata[WINDOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/blr_line_step.sv
`timescale 1ns / 1ps
// Next-state logic of the line walk: line setup on start, one Bresenham step on advance.
// Depends on blr_pkg.
module blr_line_step #(
   parameter int COORD_BITS = 11
) (
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic signed [COORD_BITS-1:0] cur_x,
   input  logic signed [COORD_BITS-1:0] cur_y,
   input  logic        [COORD_BITS-1:0] remaining,
   input  logic signed [COORD_BITS+2:0] error_term,
   input  logic        [COORD_BITS-1:0] abs_dx,
   input  logic        [COORD_BITS-1:0] abs_dy,
   input  blr_pkg::dir_type             dir,
   output logic signed [COORD_BITS-1:0] next_cur_x,
   output logic signed [COORD_BITS-1:0] next_cur_y,
   output logic        [COORD_BITS-1:0] next_remaining,
   output logic signed [COORD_BITS+2:0] next_error,
   output logic        [COORD_BITS-1:0] next_abs_dx,
   output logic        [COORD_BITS-1:0] next_abs_dy,
   output blr_pkg::dir_type             next_dir
);
   import blr_pkg::*;

   localparam int N = COORD_BITS;
   localparam int E = COORD_BITS + 3;
   localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

   logic signed [N:0]   dx, dy, neg_dx, neg_dy;
   logic        [N-1:0] adx, ady;
   logic                steep_new;
   logic        [N-1:0] major_s, minor_s, major_a, minor_a;
   logic signed [E-1:0] err_start, err_up, err_down;
   logic        [N-1:0] x_inc, y_inc;
   logic                minor_move;

   // setup
   always_comb begin
      dx        = {end_x[N-1], end_x} - {start_x[N-1], start_x};
      dy        = {end_y[N-1], end_y} - {start_y[N-1], start_y};
      neg_dx    = -dx;
      neg_dy    = -dy;
      adx       = dx[N] ? neg_dx[N-1:0] : dx[N-1:0];
      ady       = dy[N] ? neg_dy[N-1:0] : dy[N-1:0];
      steep_new = ady > adx;
      major_s   = steep_new ? ady : adx;
      minor_s   = steep_new ? adx : ady;
      err_start = $signed({2'b00, minor_s, 1'b0}) - $signed({3'b000, major_s});
   end

   // one step along the major axis
   always_comb begin
      major_a    = dir.steep ? abs_dy : abs_dx;
      minor_a    = dir.steep ? abs_dx : abs_dy;
      err_up     = $signed({2'b00, minor_a, 1'b0});
      err_down   = err_up - $signed({2'b00, major_a, 1'b0});
      minor_move = error_term > 0;
      x_inc      = dir.x_backward ? {N{1'b1}} : ONE;
      y_inc      = dir.y_backward ? {N{1'b1}} : ONE;
   end

   always_comb begin
      if (start) begin
         next_cur_x          = start_x;
         next_cur_y          = start_y;
         next_remaining      = major_s;
         next_error          = err_start;
         next_abs_dx         = adx;
         next_abs_dy         = ady;
         next_dir.steep      = steep_new;
         next_dir.x_backward = dx[N];
         next_dir.y_backward = dy[N];
      end else begin
         next_cur_x     = cur_x;
         next_cur_y     = cur_y;
         if (!dir.steep || minor_move) begin
            next_cur_x = cur_x + x_inc;
         end
         if (dir.steep || minor_move) begin
            next_cur_y = cur_y + y_inc;
         end
         next_error     = error_term + (minor_move ? err_down : err_up);
         next_remaining = remaining - ONE;
         next_abs_dx    = abs_dx;
         next_abs_dy    = abs_dy;
         next_dir       = dir;
      end
   end

endmodule

### sv/blr_pixel_map.sv
`timescale 1ns / 1ps
// Maps a logical pixel to screen coordinates and tests it against the window.
// Depends on blr_pkg.
module blr_pixel_map #(
   parameter int COORD_BITS = 11
) (
   input  logic signed [COORD_BITS-1:0]         cur_x,
   input  logic signed [COORD_BITS-1:0]         cur_y,
   input  blr_pkg::view_type                    view,
   output logic signed [blr_pkg::SCREEN_BITS-1:0] screen_x,
   output logic signed [blr_pkg::SCREEN_BITS-1:0] screen_y,
   output logic                                 in_window
);
   import blr_pkg::*;

   // wide enough for coordinate plus origin and for the window compare
   localparam int SUM_W = ((COORD_BITS + 1 > WINDOW_BITS) ? COORD_BITS + 1 : WINDOW_BITS) + 1;

   logic signed [SUM_W-1:0] cx_ext, cy_ext, ox_ext, oy_ext, sx, sy;

   always_comb begin
      cx_ext    = SUM_W'(cur_x);
      cy_ext    = SUM_W'(cur_y);
      ox_ext    = SUM_W'(view.origin_x);
      oy_ext    = SUM_W'(view.origin_y);
      sx        = cx_ext + ox_ext;
      sy        = oy_ext - cy_ext;
      in_window = !sx[SUM_W-1] && !sy[SUM_W-1]
                  && ($unsigned(sx) < SUM_W'(view.window_width))
                  && ($unsigned(sy) < SUM_W'(view.window_height));
      screen_x  = sx[SCREEN_BITS-1:0];
      screen_y  = sy[SCREEN_BITS-1:0];
   end

endmodule

### sv/blr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_unit.
module blr_checker #(
   parameter int COORD_BITS = 11,
   parameter int COLOR_BITS = 4
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] req_tdata,
   input logic                                  req_tuser,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [((2*blr_pkg::SCREEN_BITS+COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                                  rsp_tuser,
   input logic                                  rsp_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic                                  csr_we,
   input logic [blr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input logic [blr_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import blr_pkg::*;

   localparam int N = COORD_BITS;

   logic req_start, single_point;

   assign req_start    = req_tvalid && req_tready && req_tuser == CMD_START;
   assign single_point = req_tdata[N-1:0] == req_tdata[3*N-1:2*N]
                         && req_tdata[2*N-1:N] == req_tdata[4*N-1:3*N];

   // result register empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a start command always yields its first pixel next cycle
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      req_start |=> rsp_tvalid)
      else $error("start item produced no pixel");

   // a line with equal endpoints is a single, final pixel
   a_single_point_last: assert property (@(posedge clock) disable iff (reset)
      req_start && single_point |=> rsp_tlast)
      else $error("single point line not marked last");

   // with the result register empty the block must take an item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind bresenham_line_rasterizer_unit blr_checker #(
   .COORD_BITS(COORD_BITS),
   .COLOR_BITS(COLOR_BITS)
) u_blr_checker (.*);
